### design/bse_pkg.sv
`default_nettype none
package bse_pkg;

    localparam int VALUE_W  = 16;
    localparam int BKT_W    = 4;
    localparam int BCOUNT_W = 5;
    localparam int SCALED_W = VALUE_W + BCOUNT_W;

    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [BKT_W-1:0]    bkt_t;
    typedef logic [BCOUNT_W-1:0] bcount_t;
    typedef logic [SCALED_W-1:0] scaled_t;

    localparam bcount_t BUCKETS_AT_RESET = 5'd10;
    localparam bcount_t BUCKETS_LIMIT    = 5'd16;
    localparam bcount_t BUCKETS_MIN      = 5'd1;

    // top-level sequencer
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_BUCKET,
        ST_OUT
    } seq_state_t;

    // bucket search unit
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_STEP
    } bkt_state_t;

    typedef struct packed {
        logic done;
        bkt_t bucket;
    } bkt_rsp_t;

endpackage
`default_nettype wire

### design/bse_ifs.sv
`default_nettype none
interface bse_load_if;
    logic           valid;
    logic           ready;
    bse_pkg::value_t value;
    logic           last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface bse_sort_if;
    logic            valid;
    logic            ready;
    bse_pkg::value_t sorted_value;
    bse_pkg::bkt_t   bucket_index;
    logic            overflow;
    logic            last_out;

    modport source (output valid, output sorted_value, output bucket_index,
                    output overflow, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input bucket_index,
                    input overflow, input last_out, output ready);
endinterface
`default_nettype wire

### design/bse_bucket_unit.sv
`default_nettype none
module bse_bucket_unit (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  bse_pkg::value_t   value,
    input  bse_pkg::value_t   top,
    input  bse_pkg::bcount_t  nbkt,
    output bse_pkg::bkt_rsp_t rsp
);
    import bse_pkg::*;

    bkt_state_t state_reg, state_next;
    scaled_t    scaled_reg, scaled_next;
    scaled_t    acc_reg, acc_next;
    value_t     top_reg, top_next;
    bkt_t       j_reg, j_next;
    bkt_t       last_j_reg, last_j_next;
    logic       hit;

    // first bucket whose upper bound max*(j+1) reaches value*B
    assign hit = (scaled_reg <= acc_reg) || (j_reg == last_j_reg);

    always_comb
    begin
        state_next  = state_reg;
        scaled_next = scaled_reg;
        acc_next    = acc_reg;
        top_next    = top_reg;
        j_next      = j_reg;
        last_j_next = last_j_reg;
        rsp.done    = 1'b0;
        rsp.bucket  = j_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    scaled_next = SCALED_W'(value) * SCALED_W'(nbkt);
                    acc_next    = SCALED_W'(top);
                    top_next    = top;
                    j_next      = '0;
                    last_j_next = BKT_W'(nbkt - BUCKETS_MIN);
                    state_next  = BK_STEP;
                end
            end
            BK_STEP:
            begin
                if (hit)
                begin
                    rsp.done   = 1'b1;
                    state_next = BK_IDLE;
                end
                else
                begin
                    acc_next = acc_reg + SCALED_W'(top_reg);
                    j_next   = j_reg + BKT_W'(1);
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // search datapath
    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
        acc_reg    <= acc_next;
        top_reg    <= top_next;
        j_reg      <= j_next;
        last_j_reg <= last_j_next;
    end

endmodule
`default_nettype wire

### design/bucket_sort_engine.sv
`default_nettype none
// channel   dir  transfer when        payload
// load_ch   in   valid && ready       value, last_item
// sort_ch   out  valid && ready       sorted_value, bucket_index, overflow, last_out
// cfg       in   cfg_we               cfg_wdata (bucket count)
//
// load_ch is ready throughout loading; values beyond MAX_ITEMS are dropped
// and raise overflow; each sorted value then takes a store scan (one read port,
// one entry per cycle), a bucket search in the bucket unit that steps up to
// the first hit or the last bucket, and an output handshake
// load_ch is not ready from the last value of a set until its final transfer
// reset clears the sequencer and counters and sets the bucket count to 10; no clearing pass
module bucket_sort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  wire                    clk,
    input  wire                    rst_n,
    bse_load_if.sink               load_ch,
    bse_sort_if.source             sort_ch,
    input  wire                    cfg_we,
    input  bse_pkg::bcount_t       cfg_wdata
);
    import bse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    seq_state_t             state_reg, state_next;
    bcount_t                bcount_reg, bcount_next;
    cnt_t                   count_reg, count_next;
    value_t                 max_reg, max_next;
    logic                   ovf_reg, ovf_next;
    logic [MAX_ITEMS-1:0]   done_reg, done_next;
    idx_t                   scan_idx_reg, scan_idx_next;
    idx_t                   emit_reg, emit_next;
    logic                   q_vld_reg, q_vld_next;
    idx_t                   q_idx_reg, q_idx_next;
    value_t                 q_val_reg;
    logic                   best_found_reg, best_found_next;
    value_t                 best_val_reg, best_val_next;
    idx_t                   best_idx_reg, best_idx_next;
    value_t                 out_val_reg, out_val_next;
    bkt_t                   out_bkt_reg, out_bkt_next;
    logic                   out_last_reg, out_last_next;

    value_t                 store [MAX_ITEMS];
    logic                   store_we;
    bcount_t                eff_b;
    idx_t                   last_idx;
    logic                   load_xfer;
    logic                   sort_xfer;
    logic                   bkt_start;
    bkt_rsp_t               bkt_rsp;

    assign load_xfer = load_ch.valid && load_ch.ready;
    assign sort_xfer = sort_ch.valid && sort_ch.ready;
    assign last_idx  = idx_t'(count_reg - cnt_t'(1));

    // bucket count clamped to 1..16
    always_comb
    begin
        if (bcount_reg == '0)
        begin
            eff_b = BUCKETS_MIN;
        end
        else if (bcount_reg > BUCKETS_LIMIT)
        begin
            eff_b = BUCKETS_LIMIT;
        end
        else
        begin
            eff_b = bcount_reg;
        end
    end

    // handshake and output payload
    assign load_ch.ready        = (state_reg == ST_LOAD);
    assign sort_ch.valid        = (state_reg == ST_OUT);
    assign sort_ch.sorted_value = out_val_reg;
    assign sort_ch.bucket_index = out_bkt_reg;
    assign sort_ch.overflow     = ovf_reg;
    assign sort_ch.last_out     = out_last_reg;

    assign store_we  = load_xfer && (count_reg < cnt_t'(MAX_ITEMS));
    assign bkt_start = (state_reg == ST_PICK);

    bse_bucket_unit u_bkt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bkt_start),
        .value (best_val_reg),
        .top   (max_reg),
        .nbkt  (eff_b),
        .rsp   (bkt_rsp)
    );

    // sequencer: load, then per output a minimum scan and bucket search
    always_comb
    begin
        state_next      = state_reg;
        bcount_next     = bcount_reg;
        count_next      = count_reg;
        max_next        = max_reg;
        ovf_next        = ovf_reg;
        done_next       = done_reg;
        scan_idx_next   = scan_idx_reg;
        emit_next       = emit_reg;
        q_vld_next      = 1'b0;
        q_idx_next      = scan_idx_reg;
        best_found_next = best_found_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        out_val_next    = out_val_reg;
        out_bkt_next    = out_bkt_reg;
        out_last_next   = out_last_reg;

        if (cfg_we)
        begin
            bcount_next = cfg_wdata;
        end

        // running minimum over entries not yet sent
        if (q_vld_reg && (!best_found_reg || (q_val_reg < best_val_reg)))
        begin
            best_found_next = 1'b1;
            best_val_next   = q_val_reg;
            best_idx_next   = q_idx_reg;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (load_xfer)
                begin
                    if (store_we)
                    begin
                        count_next = count_reg + cnt_t'(1);
                        if (load_ch.value > max_reg)
                        begin
                            max_next = load_ch.value;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (load_ch.last_item)
                    begin
                        scan_idx_next   = '0;
                        emit_next       = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                q_vld_next = !done_reg[scan_idx_reg];
                if (scan_idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + idx_t'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_BUCKET;
            end
            ST_BUCKET:
            begin
                if (bkt_rsp.done)
                begin
                    out_val_next  = best_val_reg;
                    out_bkt_next  = bkt_rsp.bucket;
                    out_last_next = (emit_reg == last_idx);
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (sort_xfer)
                begin
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        max_next   = '0;
                        ovf_next   = 1'b0;
                        done_next  = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        done_next[best_idx_reg] = 1'b1;
                        emit_next               = emit_reg + idx_t'(1);
                        scan_idx_next           = '0;
                        best_found_next         = 1'b0;
                        state_next              = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            bcount_reg     <= BUCKETS_AT_RESET;
            count_reg      <= '0;
            max_reg        <= '0;
            ovf_reg        <= 1'b0;
            done_reg       <= '0;
            scan_idx_reg   <= '0;
            emit_reg       <= '0;
            q_vld_reg      <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bcount_reg     <= bcount_next;
            count_reg      <= count_next;
            max_reg        <= max_next;
            ovf_reg        <= ovf_next;
            done_reg       <= done_next;
            scan_idx_reg   <= scan_idx_next;
            emit_reg       <= emit_next;
            q_vld_reg      <= q_vld_next;
            best_found_reg <= best_found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        q_idx_reg    <= q_idx_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        out_val_reg  <= out_val_next;
        out_bkt_reg  <= out_bkt_next;
        out_last_reg <= out_last_next;
    end

    // value store: one write port for load, one registered read for scan
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[count_reg[IDX_W-1:0]] <= load_ch.value;
        end
        q_val_reg <= store[scan_idx_reg];
    end

endmodule
`default_nettype wire
